[sv/bclru_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package bclru_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = 4;
    localparam int RANK_W  = 4;
    localparam int CNT_W   = 5;
    localparam int BLK_W   = 31;
    localparam int TAG_W   = 47;
    localparam int OFFS_W  = 2;
    localparam int SECT_W  = 34;

    localparam logic [1:0] KIND_HIT  = 2'd0;
    localparam logic [1:0] KIND_FILL = 2'd1;
    localparam logic [1:0] KIND_WB   = 2'd2;
    localparam logic [1:0] KIND_DONE = 2'd3;

    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_SYNC   = 1'b1;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_HIT,
        CMD_NEW,
        CMD_EVICT,
        CMD_CLEAN
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op            op;
        logic [IDX_W-1:0]   sel;
        logic [TAG_W-1:0]   tag;
        logic               modify;
        logic [RANK_W-1:0]  thr;
        logic [RANK_W-1:0]  rank_new;
    } t_cmd;

    // priority results handed along the row, lowest index wins
    typedef struct packed {
        logic               hit_f;
        logic [IDX_W-1:0]   hit_idx;
        logic               free_f;
        logic [IDX_W-1:0]   free_idx;
        logic               lru_f;
        logic [IDX_W-1:0]   lru_idx;
        logic               sync_f;
        logic [IDX_W-1:0]   sync_idx;
    } t_chain;

endpackage
`default_nettype wire

[sv/block_cache_lru_writeback.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Handshake                     Content
// s_axis    in   tvalid/tready                 tuser opcode, tdata request
// m_axis    out  tvalid/tready, tlast          tuser kind, tdata result
// cfg       in   wr_en, no wait                sectors_per_block
//
// An access is accepted, then looked up in the cell row; when a dirty victim must
// be written back first, the fill follows. A sync scans one recency rank per cycle
// across the row while the output register is free, then done is sent.
// Reset clears all cells at once; sectors_per_block returns to 2.
// A stalled output holds the sequencer; the output register frees as it drains.
module block_cache_lru_writeback
    import bclru_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [47:0] i_s_axis_tdata,  // dev_major, dev_minor, block_number, modify
    input  wire logic        i_s_axis_tuser,  // opcode
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [55:0]      o_m_axis_tdata,  // entry_index, out_major, out_minor,
                                              // sector_address, block_in_page
    output logic [1:0]       o_m_axis_tuser,  // kind
    output logic             o_m_axis_tlast,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [3:0]  i_cfg_wr_data
);

    typedef enum logic [1:0] {S_IDLE, S_LOOK, S_FILL, S_SYNC} t_state;

    t_state             r_state;
    logic [3:0]         r_spb;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_sync_r;
    logic [TAG_W-1:0]   r_req_tag;
    logic [OFFS_W-1:0]  r_req_offs;
    logic               r_req_mod;
    logic [IDX_W-1:0]   r_e;

    logic               r_out_valid;
    logic [1:0]         r_out_kind;
    logic [IDX_W-1:0]   r_out_idx;
    logic [TAG_W-1:0]   r_out_tag;
    logic [OFFS_W-1:0]  r_out_offs;
    logic               r_out_last;

    t_cmd               w_cmd;
    t_chain             w_chain;
    logic [ENTRIES-1:0] w_hit_vec;
    logic [TAG_W-1:0]   w_rd_tag;
    logic               w_rd_dirty;
    logic [RANK_W-1:0]  w_rd_rank;
    logic [IDX_W-1:0]   w_rd_idx;
    logic [IDX_W-1:0]   w_victim;
    logic               w_slot_free;
    logic               w_in_acc;
    logic [34:0]        w_prod;

    assign w_slot_free     = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_victim        = w_chain.lru_f ? w_chain.lru_idx : '0;

    always_comb begin
        if (r_state == S_SYNC) begin
            w_rd_idx = w_chain.sync_idx;
        end else if (w_chain.hit_f) begin
            w_rd_idx = w_chain.hit_idx;
        end else begin
            w_rd_idx = w_victim;
        end
    end

    bclru_row u_row (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tag       (r_req_tag),
        .i_sync_rank (r_sync_r[RANK_W-1:0]),
        .i_cmd       (w_cmd),
        .i_rd_idx    (w_rd_idx),
        .o_chain     (w_chain),
        .o_hit_vec   (w_hit_vec),
        .o_rd_tag    (w_rd_tag),
        .o_rd_dirty  (w_rd_dirty),
        .o_rd_rank   (w_rd_rank)
    );

    always_comb begin
        w_cmd          = '0;
        w_cmd.op       = CMD_NONE;
        w_cmd.tag      = r_req_tag;
        w_cmd.modify   = r_req_mod;
        w_cmd.thr      = w_rd_rank;
        w_cmd.rank_new = RANK_W'(r_count - 1'b1);
        if (r_state == S_LOOK && w_slot_free) begin
            if (w_chain.hit_f) begin
                w_cmd.op  = CMD_HIT;
                w_cmd.sel = w_chain.hit_idx;
            end else if (r_count < CNT_W'(ENTRIES)) begin
                w_cmd.op       = CMD_NEW;
                w_cmd.sel      = w_chain.free_idx;
                w_cmd.rank_new = r_count[RANK_W-1:0];
            end else begin
                w_cmd.op  = CMD_EVICT;
                w_cmd.sel = w_victim;
            end
        end else if (r_state == S_SYNC && w_slot_free && r_sync_r < r_count
                     && w_chain.sync_f) begin
            w_cmd.op  = CMD_CLEAN;
            w_cmd.sel = w_chain.sync_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_spb       <= 4'd2;
            r_count     <= '0;
            r_sync_r    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_spb <= i_cfg_wr_data;
            end
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_req_tag  <= {i_s_axis_tdata[7:0], i_s_axis_tdata[15:8],
                                       i_s_axis_tdata[46:18], 2'b00};
                        r_req_offs <= i_s_axis_tdata[17:16];
                        r_req_mod  <= i_s_axis_tdata[47];
                        r_sync_r   <= '0;
                        r_state    <= (i_s_axis_tuser == OP_SYNC) ? S_SYNC : S_LOOK;
                    end
                end
                S_LOOK: begin
                    if (w_slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_tag   <= r_req_tag;
                        r_out_offs  <= r_req_offs;
                        r_out_last  <= 1'b1;
                        r_out_kind  <= KIND_FILL;
                        r_state     <= S_IDLE;
                        if (w_chain.hit_f) begin
                            r_out_kind <= KIND_HIT;
                            r_out_idx  <= w_chain.hit_idx;
                        end else if (r_count < CNT_W'(ENTRIES)) begin
                            r_out_idx <= w_chain.free_idx;
                            r_count   <= r_count + 1'b1;
                        end else begin
                            r_out_idx <= w_victim;
                            r_e       <= w_victim;
                            if (w_rd_dirty) begin
                                // write back the victim first, fill next
                                r_out_kind <= KIND_WB;
                                r_out_tag  <= w_rd_tag;
                                r_out_offs <= '0;
                                r_out_last <= 1'b0;
                                r_state    <= S_FILL;
                            end
                        end
                    end
                end
                S_FILL: begin
                    if (w_slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= KIND_FILL;
                        r_out_idx   <= r_e;
                        r_out_tag   <= r_req_tag;
                        r_out_offs  <= r_req_offs;
                        r_out_last  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_SYNC: begin
                    if (w_slot_free) begin
                        if (r_sync_r < r_count) begin
                            r_sync_r <= r_sync_r + 1'b1;
                            if (w_chain.sync_f) begin
                                r_out_valid <= 1'b1;
                                r_out_kind  <= KIND_WB;
                                r_out_idx   <= w_chain.sync_idx;
                                r_out_tag   <= w_rd_tag;
                                r_out_offs  <= '0;
                                r_out_last  <= 1'b0;
                            end
                        end else begin
                            r_out_valid <= 1'b1;
                            r_out_kind  <= KIND_DONE;
                            r_out_idx   <= '0;
                            r_out_tag   <= '0;
                            r_out_offs  <= '0;
                            r_out_last  <= 1'b1;
                            r_state     <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign w_prod = 35'(r_out_tag[BLK_W-1:0]) * 35'(r_spb);

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {r_out_offs, w_prod[SECT_W-1:0],
                              r_out_tag[38:31], r_out_tag[46:39], r_out_idx};

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(ENTRIES))
        else $error("entry count beyond capacity");

    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LOOK |-> $onehot0(w_hit_vec))
        else $error("tag held by more than one entry");

    a_free_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK && r_count < CNT_W'(ENTRIES)) |-> w_chain.free_f)
        else $error("count below capacity but no unused entry");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid) && r_out_last && !$past(r_state == S_IDLE))
        |-> r_state == S_IDLE)
        else $error("final result sent while item still in work");

endmodule
`default_nettype wire

[sv/bclru_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
module bclru_cell
    import bclru_pkg::*;
#(
    parameter logic [IDX_W-1:0] IDX = '0
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [TAG_W-1:0]  i_tag,
    input  wire logic [RANK_W-1:0] i_sync_rank,
    input  wire t_cmd              i_cmd,
    input  wire t_chain            i_chain,
    output t_chain                 o_chain,
    output logic                   o_hit,
    output logic [TAG_W-1:0]       o_tag,
    output logic                   o_dirty,
    output logic [RANK_W-1:0]      o_rank
);

    logic              r_valid;
    logic              r_dirty;
    logic [RANK_W-1:0] r_rank;
    logic [TAG_W-1:0]  r_tag;
    logic              w_sel;

    assign w_sel = (i_cmd.sel == IDX);
    assign o_hit = r_valid && (r_tag == i_tag);

    always_comb begin
        o_chain = i_chain;
        if (!i_chain.hit_f && o_hit) begin
            o_chain.hit_f   = 1'b1;
            o_chain.hit_idx = IDX;
        end
        if (!i_chain.free_f && !r_valid) begin
            o_chain.free_f   = 1'b1;
            o_chain.free_idx = IDX;
        end
        if (!i_chain.lru_f && r_valid && r_rank == '0) begin
            o_chain.lru_f   = 1'b1;
            o_chain.lru_idx = IDX;
        end
        if (!i_chain.sync_f && r_valid && r_dirty && r_rank == i_sync_rank) begin
            o_chain.sync_f   = 1'b1;
            o_chain.sync_idx = IDX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_dirty <= 1'b0;
            r_rank  <= '0;
        end else begin
            case (i_cmd.op)
                CMD_HIT, CMD_EVICT: begin
                    if (w_sel) begin
                        r_rank <= i_cmd.rank_new;
                        if (i_cmd.op == CMD_HIT) begin
                            r_dirty <= r_dirty | i_cmd.modify;
                        end else begin
                            r_dirty <= i_cmd.modify;
                        end
                    end else if (r_valid && r_rank > i_cmd.thr) begin
                        r_rank <= r_rank - 1'b1;
                    end
                end
                CMD_NEW: begin
                    if (w_sel) begin
                        r_valid <= 1'b1;
                        r_rank  <= i_cmd.rank_new;
                        r_dirty <= i_cmd.modify;
                    end
                end
                CMD_CLEAN: begin
                    if (w_sel) begin
                        r_dirty <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sel && (i_cmd.op == CMD_NEW || i_cmd.op == CMD_EVICT)) begin
            r_tag <= i_cmd.tag;
        end
    end

    assign o_tag   = r_tag;
    assign o_dirty = r_dirty;
    assign o_rank  = r_rank;

endmodule
`default_nettype wire

[sv/bclru_row.sv]
`timescale 1ns / 1ps
`default_nettype none
module bclru_row
    import bclru_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [TAG_W-1:0]  i_tag,
    input  wire logic [RANK_W-1:0] i_sync_rank,
    input  wire t_cmd              i_cmd,
    input  wire logic [IDX_W-1:0]  i_rd_idx,
    output t_chain                 o_chain,
    output logic [ENTRIES-1:0]     o_hit_vec,
    output logic [TAG_W-1:0]       o_rd_tag,
    output logic                   o_rd_dirty,
    output logic [RANK_W-1:0]      o_rd_rank
);

    t_chain            w_chain [ENTRIES+1];
    logic [TAG_W-1:0]  w_tag   [ENTRIES];
    logic              w_dirty [ENTRIES];
    logic [RANK_W-1:0] w_rank  [ENTRIES];

    assign w_chain[0] = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        bclru_cell #(
            .IDX(IDX_W'(g))
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_tag       (i_tag),
            .i_sync_rank (i_sync_rank),
            .i_cmd       (i_cmd),
            .i_chain     (w_chain[g]),
            .o_chain     (w_chain[g+1]),
            .o_hit       (o_hit_vec[g]),
            .o_tag       (w_tag[g]),
            .o_dirty     (w_dirty[g]),
            .o_rank      (w_rank[g])
        );
    end

    assign o_chain    = w_chain[ENTRIES];
    assign o_rd_tag   = w_tag[i_rd_idx];
    assign o_rd_dirty = w_dirty[i_rd_idx];
    assign o_rd_rank  = w_rank[i_rd_idx];

endmodule
`default_nettype wire
